### rtl/core/apcp_pkg.sv
`default_nettype none

package apcp_pkg;

   // character codes
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_NUL   = 8'd0;

   // parser phases, one-hot
   typedef enum logic [6:0] {
      PH_LEAD = 7'b0000001,
      PH_X    = 7'b0000010,
      PH_GAP  = 7'b0000100,
      PH_Y    = 7'b0001000,
      PH_XNEG = 7'b0010000,
      PH_YNEG = 7'b0100000,
      PH_CMD  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } apcp_req_type;

   typedef struct packed {
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic [7:0]         command;
      logic               command_fresh;
   } apcp_rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] x_acc;
      logic [31:0] y_acc;
      logic [7:0]  held_command;
      logic        finished;
   } apcp_state_type;

endpackage

`default_nettype wire

### rtl/core/apcp_step.sv
`default_nettype none

module apcp_step (
   input  apcp_pkg::apcp_state_type cur_state,
   input  apcp_pkg::apcp_req_type   req,
   output apcp_pkg::apcp_state_type nxt_state,
   output logic                     emit,
   output apcp_pkg::apcp_rsp_type   rsp
);
   import apcp_pkg::*;

   apcp_state_type eff;
   logic [7:0]     b;
   logic           is_digit;
   logic           is_space;
   logic           is_minus;
   logic [31:0]    dval;
   logic [31:0]    x_mac;
   logic [31:0]    y_mac;
   logic [31:0]    y_mas;
   logic [31:0]    x_neg;
   logic           fresh;

   assign b        = req.data_byte;
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign is_space = (b == CH_SPACE);
   assign is_minus = (b == CH_MINUS);
   // digits are 0x30..0x39, so the low nibble is the digit value
   assign dval     = {28'd0, b[3:0]};

   // start request clears values, phase and done flag before the byte is looked at
   always_comb begin
      eff = cur_state;
      if (req.start_req) begin
         eff.x_acc    = '0;
         eff.y_acc    = '0;
         eff.phase    = PH_LEAD;
         eff.finished = 1'b0;
      end
   end

   assign x_mac = (eff.x_acc << 3) + (eff.x_acc << 1) + dval;
   assign y_mac = (eff.y_acc << 3) + (eff.y_acc << 1) + dval;
   assign y_mas = (eff.y_acc << 3) + (eff.y_acc << 1) - dval;
   assign x_neg = 32'd0 - eff.x_acc;

   always_comb begin
      nxt_state = eff;
      emit      = 1'b0;
      fresh     = 1'b0;
      if (eff.finished) begin
         emit = 1'b0;
      end else if ((b == CH_NUL) && (eff.phase != PH_CMD)) begin
         // zero byte ends the message with values so far, except in the command phase
         emit = 1'b1;
      end else begin
         unique case (eff.phase)
            PH_LEAD: begin
               if (is_space) begin
                  nxt_state.phase = PH_LEAD;
               end else if (is_minus) begin
                  nxt_state.phase = PH_XNEG;
               end else if (is_digit) begin
                  nxt_state.x_acc = x_mac;
                  nxt_state.phase = PH_X;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_X: begin
               if (is_digit) begin
                  nxt_state.x_acc = x_mac;
               end else if (is_space) begin
                  nxt_state.phase = PH_GAP;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_GAP: begin
               if (is_space) begin
                  nxt_state.phase = PH_GAP;
               end else if (is_digit) begin
                  nxt_state.y_acc = y_mac;
                  nxt_state.phase = PH_Y;
               end else if (is_minus) begin
                  nxt_state.phase = PH_YNEG;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_Y: begin
               if (is_digit) begin
                  nxt_state.y_acc = y_mac;
               end else if (is_space) begin
                  nxt_state.phase = PH_CMD;
               end else begin
                  nxt_state.held_command = b;
                  fresh                  = 1'b1;
                  emit                   = 1'b1;
               end
            end
            PH_XNEG: begin
               if (is_digit) begin
                  nxt_state.x_acc = x_mac;
               end else begin
                  // negate, then handle the byte as in the gap
                  nxt_state.x_acc = x_neg;
                  nxt_state.phase = PH_GAP;
                  if (is_minus) begin
                     nxt_state.phase = PH_YNEG;
                  end else if (!is_space) begin
                     emit = 1'b1;
                  end
               end
            end
            PH_YNEG: begin
               if (is_digit) begin
                  nxt_state.y_acc = y_mas;
               end else if (is_space) begin
                  nxt_state.phase = PH_CMD;
               end else begin
                  nxt_state.held_command = b;
                  fresh                  = 1'b1;
                  emit                   = 1'b1;
               end
            end
            PH_CMD: begin
               if (!is_space) begin
                  nxt_state.held_command = b;
                  fresh                  = 1'b1;
                  emit                   = 1'b1;
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end
      if (emit) begin
         nxt_state.finished = 1'b1;
      end
   end

   assign rsp.x_value       = nxt_state.x_acc;
   assign rsp.y_value       = nxt_state.y_acc;
   assign rsp.command       = nxt_state.held_command;
   assign rsp.command_fresh = fresh;

endmodule

`default_nettype wire

### rtl/core/ascii_pointer_command_parser.sv
// output: a result appears on rsp in the cycle after the byte that ends the message is taken
// throughput: one byte per cycle while no result is stalled, set by the combinational parser step
// a byte is held off only while a result sits in the output register and is stalled
// reset: parser waits for a start request, values and held command are zero,
// output register empty
`default_nettype none

module ascii_pointer_command_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  apcp_pkg::apcp_req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output apcp_pkg::apcp_rsp_type rsp_payload
);
   import apcp_pkg::*;

   // parser state: phase, accumulators, held command, done flag
   apcp_state_type state_ff;
   apcp_state_type state_in;

   // output register
   apcp_rsp_type   rsp_ff;
   logic           rsp_valid_ff;

   // step results
   logic           emit;
   apcp_rsp_type   step_rsp;
   logic           req_take;
   logic           rsp_take;

   // output register frees this cycle if its result is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // one byte of the parse: start clear, phase step, accumulate, finish
   apcp_step u_step (
      .cur_state (state_ff),
      .req       (req_payload),
      .nxt_state (state_in),
      .emit      (emit),
      .rsp       (step_rsp)
   );

   // parser state advances on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_LEAD;
         state_ff.x_acc        <= '0;
         state_ff.y_acc        <= '0;
         state_ff.held_command <= '0;
         state_ff.finished     <= 1'b1;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result register: loads when a message ends, clears when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && emit) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
